// File: rtl/core/ebid_pkg.sv
// Shared types and constants for the ELF build-id note parser.
`timescale 1ns / 1ps

package ebid_pkg;

    localparam int SEG_W             = 17;
    localparam int MAX_SEGMENT_BYTES = 65536;
    localparam int MAX_ID_BYTES      = 64;
    localparam int HDR_BYTES         = 12;
    localparam int BUILD_ID_TYPE     = 3;
    localparam int OUT_DEPTH         = 4;
    localparam int OUT_PTR_W         = $clog2(OUT_DEPTH);
    localparam int OUT_LVL_W         = $clog2(OUT_DEPTH + 1);

    localparam logic KIND_HEX    = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] hex_char;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } push_t;

endpackage

// File: rtl/core/ebid_parser.sv
// Note walker: parser state and per-byte result generation.
`timescale 1ns / 1ps

module ebid_parser (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    input  logic [7:0]               item_byte,
    input  logic [ebid_pkg::SEG_W-1:0] segment_length,
    output ebid_pkg::push_t          push
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_NAME   = 2'd1;
    localparam logic [1:0] PH_DESC   = 2'd2;

    localparam int SW = ebid_pkg::SEG_W;

    logic [SW-1:0] seen_reg, seen_next;
    logic [1:0]    phase_reg, phase_next;
    logic [31:0]   ns_reg, ns_next;
    logic [31:0]   ds_reg, ds_next;
    logic [31:0]   ty_reg, ty_next;
    logic [SW-1:0] fbl_reg, fbl_next;
    logic          q_reg, q_next;
    logic          fin_reg, fin_next;

    function automatic logic [32:0] pad4(input logic [31:0] n);
        logic [32:0] s;
        begin
            s = {1'b0, n} + 33'd3;
            pad4 = {s[32:2], 2'b00};
        end
    endfunction

    function automatic logic [7:0] hex_of(input logic [3:0] n);
        begin
            if (n < 4'd10)
                hex_of = 8'h30 + {4'h0, n};
            else
                hex_of = 8'h61 + {4'h0, n} - 8'd10;
        end
    endfunction

    function automatic logic [7:0] owner_byte(input logic [1:0] i);
        begin
            case (i)
                2'd0:    owner_byte = 8'h47;
                2'd1:    owner_byte = 8'h4E;
                2'd2:    owner_byte = 8'h55;
                default: owner_byte = 8'h00;
            endcase
        end
    endfunction

    ebid_pkg::result_t status_res;
    assign status_res = '{kind: ebid_pkg::KIND_STATUS, hex_char: 8'h00, last: 1'b0};

    always_comb
    begin
        logic          go_desc;
        logic          go_end;
        logic [SW-1:0] remain;
        logic [3:0]    pos;
        logic [4:0]    sh;
        logic [32:0]   np;
        logic [32:0]   dp;
        logic [33:0]   room;
        logic [1:0]    nidx;
        logic [7:0]    pd8;
        logic [6:0]    didx;
        logic          emit;
        logic          last;

        seen_next  = seen_reg;
        phase_next = phase_reg;
        ns_next    = ns_reg;
        ds_next    = ds_reg;
        ty_next    = ty_reg;
        fbl_next   = fbl_reg;
        q_next     = q_reg;
        fin_next   = fin_reg;
        push       = '0;
        go_desc    = 1'b0;
        go_end     = 1'b0;
        remain     = segment_length - (seen_reg + SW'(1));
        pos        = fbl_reg[3:0];
        sh         = {pos[1:0], 3'b000};
        np         = '0;
        dp         = '0;
        room       = '0;
        nidx       = 2'(3'd4 - fbl_reg[2:0]);
        pd8        = ({1'b0, ds_reg[6:0]} + 8'd3) & 8'hFC;
        didx       = pd8[6:0] - fbl_reg[6:0];
        emit       = 1'b0;
        last       = 1'b0;

        if (item_valid && !fin_reg &&
            ({15'b0, segment_length} <= 32'(ebid_pkg::MAX_SEGMENT_BYTES)))
        begin
            if (seen_reg >= segment_length)
            begin
                fin_next   = 1'b1;
                push.count = 2'd1;
                push.res0  = status_res;
            end
            else if (phase_reg != PH_NAME && phase_reg != PH_DESC && fbl_reg == '0 &&
                     (segment_length - seen_reg) < SW'(ebid_pkg::HDR_BYTES))
            begin
                phase_next = PH_HEADER;
                fin_next   = 1'b1;
                push.count = 2'd1;
                push.res0  = status_res;
            end
            else
            begin
                seen_next = seen_reg + SW'(1);
                case (phase_reg)
                    PH_NAME:
                    begin
                        if (q_reg && item_byte != owner_byte(nidx))
                            q_next = 1'b0;
                        fbl_next = fbl_reg - SW'(1);
                        if (fbl_next == '0)
                            go_desc = 1'b1;
                    end
                    PH_DESC:
                    begin
                        emit     = q_reg && (didx < ds_reg[6:0]);
                        last     = (didx + 7'd1) == ds_reg[6:0];
                        fbl_next = fbl_reg - SW'(1);
                        if (emit)
                        begin
                            push.count = 2'd2;
                            push.res0  = '{kind: ebid_pkg::KIND_HEX,
                                           hex_char: hex_of(item_byte[7:4]), last: 1'b0};
                            push.res1  = '{kind: ebid_pkg::KIND_HEX,
                                           hex_char: hex_of(item_byte[3:0]), last: last};
                            if (last)
                                fin_next = 1'b1;
                            else if (fbl_next == '0)
                                go_end = 1'b1;
                        end
                        else if (fbl_next == '0)
                            go_end = 1'b1;
                    end
                    default:
                    begin
                        phase_next = PH_HEADER;
                        if (pos == 4'd0)
                        begin
                            ns_next = '0;
                            ds_next = '0;
                            ty_next = '0;
                        end
                        if (pos < 4'd4)
                            ns_next[sh +: 8] = item_byte;
                        else if (pos < 4'd8)
                            ds_next[sh +: 8] = item_byte;
                        else
                            ty_next[sh +: 8] = item_byte;
                        fbl_next = SW'(pos) + SW'(1);
                        if (pos == 4'(ebid_pkg::HDR_BYTES - 1))
                        begin
                            fbl_next = '0;
                            np       = pad4(ns_next);
                            dp       = pad4(ds_next);
                            room     = {17'b0, remain} - {1'b0, np};
                            if (np > {16'b0, remain})
                            begin
                                fin_next   = 1'b1;
                                push.count = 2'd1;
                                push.res0  = status_res;
                            end
                            else if ({1'b0, dp} > room)
                            begin
                                fin_next   = 1'b1;
                                push.count = 2'd1;
                                push.res0  = status_res;
                            end
                            else
                            begin
                                q_next = (ty_next == 32'(ebid_pkg::BUILD_ID_TYPE)) &&
                                         (ns_next == 32'd4) && (ds_next != 32'd0) &&
                                         (ds_next <= 32'(ebid_pkg::MAX_ID_BYTES));
                                if (np == '0)
                                    go_desc = 1'b1;
                                else
                                begin
                                    phase_next = PH_NAME;
                                    fbl_next   = np[SW-1:0];
                                end
                            end
                        end
                    end
                endcase

                if (go_desc)
                begin
                    dp = pad4(ds_next);
                    if (dp == '0)
                        go_end = 1'b1;
                    else
                    begin
                        phase_next = PH_DESC;
                        fbl_next   = dp[SW-1:0];
                    end
                end

                if (go_end)
                begin
                    phase_next = PH_HEADER;
                    fbl_next   = '0;
                    if (remain < SW'(ebid_pkg::HDR_BYTES) && push.count == 2'd0)
                    begin
                        fin_next   = 1'b1;
                        push.count = 2'd1;
                        push.res0  = status_res;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg  <= '0;
            phase_reg <= PH_HEADER;
            ns_reg    <= '0;
            ds_reg    <= '0;
            ty_reg    <= '0;
            fbl_reg   <= '0;
            q_reg     <= 1'b0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            seen_reg  <= seen_next;
            phase_reg <= phase_next;
            ns_reg    <= ns_next;
            ds_reg    <= ds_next;
            ty_reg    <= ty_next;
            fbl_reg   <= fbl_next;
            q_reg     <= q_next;
            fin_reg   <= fin_next;
        end
    end

endmodule

// File: rtl/core/ebid_out_fifo.sv
// Result queue: takes up to two results a cycle, delivers one per transfer.
`timescale 1ns / 1ps

module ebid_out_fifo (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ebid_pkg::push_t                  push,
    output logic                             out_valid,
    input  logic                             out_stall,
    output ebid_pkg::result_t                out_res,
    output logic [ebid_pkg::OUT_LVL_W-1:0]   level
);

    localparam int PW = ebid_pkg::OUT_PTR_W;
    localparam int LW = ebid_pkg::OUT_LVL_W;

    ebid_pkg::result_t mem_reg [ebid_pkg::OUT_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0] level_reg, level_next;
    logic          pop;

    assign out_valid = level_reg != '0;
    assign out_res   = mem_reg[rd_ptr_reg];
    assign level     = level_reg;
    assign pop       = out_valid && !out_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(push.count);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        level_next  = level_reg + LW'(push.count) - LW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem_reg[wr_ptr_reg] <= push.res0;
        if (push.count == 2'd2)
            mem_reg[wr_ptr_reg + PW'(1)] <= push.res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

// File: rtl/core/elf_build_id_note_parser.sv
// Top level: byte input register, config register, parser and result queue.
//
//   channel  | signals                                    | role
//   note     | note_valid, note_stall, note_byte          | segment bytes in
//   result   | result_valid, result_stall, result_kind,   | hex chars / status out
//            | hex_char, last_of_id                       |
//   config   | psel, penable, pwrite, paddr, pwdata,      | segment_length at 0x0
//            | prdata, pready                             |
//
// One byte per cycle while no build id is being emitted and result_stall is low;
// each build-id byte yields two characters and the result port drains one per cycle
// unless stalled, so during the id bytes are held back. Bytes and results are registered.
// Reset (rst_n low, async) returns the parser to the first note header.
// The input register holds its byte under note_stall until the queue has room for two.
`timescale 1ns / 1ps

module elf_build_id_note_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        note_valid,
    output logic        note_stall,
    input  logic [7:0]  note_byte,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        result_kind,
    output logic [7:0]  hex_char,
    output logic        last_of_id,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SW = ebid_pkg::SEG_W;
    localparam int LW = ebid_pkg::OUT_LVL_W;

    logic [SW-1:0]     seg_len_reg;
    logic              in_full_reg, in_full_next;
    logic [7:0]        in_byte_reg;
    logic              accept;
    logic              advance;
    logic [LW-1:0]     level;
    ebid_pkg::push_t   push;
    ebid_pkg::result_t out_res;

    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == 1'b0) ? {{(32 - SW){1'b0}}, seg_len_reg} : 32'h0;
    assign advance    = in_full_reg && (level <= LW'(ebid_pkg::OUT_DEPTH - 2));
    assign note_stall = in_full_reg && !advance;
    assign accept     = note_valid && !note_stall;

    always_comb
    begin
        in_full_next = in_full_reg;
        if (accept)
            in_full_next = 1'b1;
        else if (advance)
            in_full_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
            seg_len_reg <= '0;
        end
        else
        begin
            in_full_reg <= in_full_next;
            if (psel && penable && pwrite && pready && paddr[2] == 1'b0)
                seg_len_reg <= pwdata[SW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_byte_reg <= note_byte;
    end

    ebid_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (advance),
        .item_byte      (in_byte_reg),
        .segment_length (seg_len_reg),
        .push           (push)
    );

    ebid_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .out_valid (result_valid),
        .out_stall (result_stall),
        .out_res   (out_res),
        .level     (level)
    );

    assign result_kind = out_res.kind;
    assign hex_char    = out_res.hex_char;
    assign last_of_id  = out_res.last;

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= LW'(ebid_pkg::OUT_DEPTH))
        else $error("result queue overflow");

    a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
        note_stall |=> in_full_reg && $stable(in_byte_reg))
        else $error("held byte lost while stalled");

    a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_kind |-> hex_char == 8'h00 && !last_of_id)
        else $error("status result carries character data");

    a_pair_is_hex: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> push.res0.kind == ebid_pkg::KIND_HEX &&
                               push.res1.kind == ebid_pkg::KIND_HEX)
        else $error("two-result transfer is not a hex pair");

endmodule

// File: verif/tb_elf_build_id_note_parser.sv
// Self-checking testbench for the ELF build-id note parser: bytes in, hex/status results out.
`timescale 1ns / 1ps

module tb_elf_build_id_note_parser;

    localparam int          IDLE_LIMIT   = 2000;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          SEG_W        = ebid_pkg::SEG_W;
    localparam int          HDR_BYTES    = ebid_pkg::HDR_BYTES;
    localparam int          MAX_SEG      = ebid_pkg::MAX_SEGMENT_BYTES;
    localparam int          MAX_ID       = ebid_pkg::MAX_ID_BYTES;
    localparam int          ID_TYPE      = ebid_pkg::BUILD_ID_TYPE;
    localparam logic [2:0]  SEG_LEN_ADDR = 3'd0;
    localparam logic [127:0] HEX_DIGITS  = "0123456789abcdef";
    localparam logic [31:0] GNU_OWNER_LE = 32'h00554E47;

    typedef enum logic [1:0] {WALK_HEADER, WALK_NAME, WALK_DESC} walk_phase_t;
    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_pat_t;
    typedef enum logic [2:0] {
        END_BUILD_ID, END_SHORT_TAIL, END_AFTER_NOTE, END_HEADER_OVERRUN, END_ZERO_LENGTH
    } ending_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        note_valid   = 1'b0;
    logic        note_stall;
    logic [7:0]  note_byte    = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic        result_kind;
    logic [7:0]  hex_char;
    logic        last_of_id;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic [31:0] prdata;
    logic        pready;

    // parser state as predicted
    logic [SEG_W-1:0] seg_len     = '0;
    logic [SEG_W-1:0] seen_cnt    = '0;
    walk_phase_t      walk        = WALK_HEADER;
    logic [31:0]      name_sz     = '0;
    logic [31:0]      desc_sz     = '0;
    logic [31:0]      note_type   = '0;
    logic [SEG_W-1:0] field_left  = '0;
    logic             id_note     = 1'b0;
    logic             search_done = 1'b0;

    ebid_pkg::result_t expect_q[$];
    logic [7:0]        byte_q[$];

    logic        note_xfer    = 1'b0;
    int          err_cnt      = 0;
    int          idle_cnt     = 0;
    int          bytes_in     = 0;
    int          results_seen = 0;
    int          cfg_writes   = 0;
    int          burst_left   = 0;
    int          gap_left     = 0;
    int          stall_run    = 0;
    stall_pat_t  stall_pat    = STALL_NONE;

    elf_build_id_note_parser u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .note_valid   (note_valid),
        .note_stall   (note_stall),
        .note_byte    (note_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_kind  (result_kind),
        .hex_char     (hex_char),
        .last_of_id   (last_of_id),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic longint unsigned pad4(input longint unsigned n);
        return (n + 64'd3) & ~64'd3;
    endfunction

    function automatic void close_search();
        ebid_pkg::result_t r;
        r.kind     = ebid_pkg::KIND_STATUS;
        r.hex_char = '0;
        r.last     = 1'b0;
        expect_q.push_back(r);
        search_done = 1'b1;
    endfunction

    function automatic void close_note();
        walk       = WALK_HEADER;
        field_left = '0;
        if (seg_len - seen_cnt < HDR_BYTES)
            close_search();
    endfunction

    function automatic void open_desc();
        longint unsigned dp;
        dp = pad4(desc_sz);
        if (dp == 0)
            close_note();
        else
        begin
            walk       = WALK_DESC;
            field_left = dp[SEG_W-1:0];
        end
    endfunction

    function automatic void predict_byte(input logic [7:0] b);
        longint unsigned   np;
        longint unsigned   dp;
        longint unsigned   remain;
        longint unsigned   idx;
        int unsigned       pos;
        ebid_pkg::result_t r;
        if (search_done || seg_len > MAX_SEG)
            return;
        if (seen_cnt >= seg_len)
        begin
            close_search();
            return;
        end
        if (walk == WALK_HEADER && field_left == 0 && seg_len - seen_cnt < HDR_BYTES)
        begin
            close_search();
            return;
        end
        seen_cnt++;
        remain = seg_len - seen_cnt;
        case (walk)
            WALK_NAME:
            begin
                idx = pad4(name_sz) - field_left;
                if (id_note && idx < 4 && b != GNU_OWNER_LE[8*idx +: 8])
                    id_note = 1'b0;
                field_left--;
                if (field_left == 0)
                    open_desc();
            end
            WALK_DESC:
            begin
                idx = pad4(desc_sz) - field_left;
                field_left--;
                if (id_note && idx < desc_sz)
                begin
                    r.kind     = ebid_pkg::KIND_HEX;
                    r.hex_char = HEX_DIGITS[8*(15 - b[7:4]) +: 8];
                    r.last     = 1'b0;
                    expect_q.push_back(r);
                    r.hex_char = HEX_DIGITS[8*(15 - b[3:0]) +: 8];
                    r.last     = (idx + 1 == desc_sz);
                    expect_q.push_back(r);
                    if (r.last)
                        search_done = 1'b1;
                end
                else if (field_left == 0)
                    close_note();
            end
            default:
            begin
                pos = field_left;
                if (pos == 0)
                begin
                    name_sz   = '0;
                    desc_sz   = '0;
                    note_type = '0;
                end
                if (pos < 4)
                    name_sz[8*(pos & 3) +: 8] = b;
                else if (pos < 8)
                    desc_sz[8*(pos & 3) +: 8] = b;
                else
                    note_type[8*(pos & 3) +: 8] = b;
                field_left = SEG_W'(pos + 1);
                if (field_left == HDR_BYTES)
                begin
                    field_left = '0;
                    np = pad4(name_sz);
                    dp = pad4(desc_sz);
                    if (np > remain || dp > remain - np)
                        close_search();
                    else
                    begin
                        id_note = (note_type == ID_TYPE) && (name_sz == 4) &&
                                  (desc_sz >= 1) && (desc_sz <= MAX_ID);
                        if (np == 0)
                            open_desc();
                        else
                        begin
                            walk       = WALK_NAME;
                            field_left = np[SEG_W-1:0];
                        end
                    end
                end
            end
        endcase
    endfunction

    function automatic void queue_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            byte_q.push_back(w[8*i +: 8]);
    endfunction

    function automatic void queue_random(input int n);
        for (int i = 0; i < n; i++)
            byte_q.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void queue_note(input logic [31:0] nsz, input logic [31:0] dsz,
                                       input logic [31:0] ntype, input logic [31:0] owner,
                                       input bit use_owner);
        int np;
        np = int'(pad4(nsz));
        queue_word(nsz);
        queue_word(dsz);
        queue_word(ntype);
        for (int i = 0; i < np; i++)
            byte_q.push_back((use_owner && i < 4) ? owner[8*i +: 8]
                                                  : 8'($urandom_range(0, 255)));
        queue_random(int'(pad4(dsz)));
    endfunction

    task automatic drain_idle();
        while (byte_q.size() != 0 || note_valid || expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_seg_len(input logic [SEG_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SEG_LEN_ADDR;
        pwdata  <= {{(32-SEG_W){1'b0}}, value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {{(32-SEG_W){1'b0}}, value})
        begin
            $error("segment_length readback: expected %0d, actual %0d", value, prdata);
            err_cnt++;
        end
        cfg_writes++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    always @(negedge clk)
    begin : sender
        if (!note_valid || note_xfer)
        begin
            if (gap_left != 0 || byte_q.size() == 0)
            begin
                note_valid <= 1'b0;
                if (gap_left != 0)
                    gap_left--;
            end
            else
            begin
                note_valid <= 1'b1;
                note_byte  <= byte_q.pop_front();
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end
                else
                    burst_left--;
            end
        end
    end

    always @(negedge clk)
    begin : receiver
        if (stall_run == 0)
        begin
            stall_pat = stall_pat_t'($urandom_range(0, 3));
            stall_run = $urandom_range(6, 60);
        end
        stall_run--;
        case (stall_pat)
            STALL_NONE:  result_stall <= 1'b0;
            STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
            default:     result_stall <= ~result_stall;
        endcase
    end

    always @(posedge clk)
    begin : monitor
        ebid_pkg::result_t want;
        logic              res_xfer;
        note_xfer = rst_n && note_valid && !note_stall;
        res_xfer  = rst_n && result_valid && !result_stall;
        if (rst_n && psel && penable && pwrite && pready)
            seg_len = pwdata[SEG_W-1:0];
        if (note_xfer)
        begin
            predict_byte(note_byte);
            bytes_in++;
        end
        if (res_xfer)
        begin
            if (expect_q.size() == 0)
            begin
                $error("unexpected result: result_kind %0d hex_char %h last_of_id %0d",
                       result_kind, hex_char, last_of_id);
                err_cnt++;
            end
            else
            begin
                want = expect_q.pop_front();
                if (result_kind !== want.kind)
                begin
                    $error("result_kind: expected %0d, actual %0d", want.kind, result_kind);
                    err_cnt++;
                end
                if (hex_char !== want.hex_char)
                begin
                    $error("hex_char: expected %h, actual %h", want.hex_char, hex_char);
                    err_cnt++;
                end
                if (last_of_id !== want.last)
                begin
                    $error("last_of_id: expected %0d, actual %0d", want.last, last_of_id);
                    err_cnt++;
                end
                results_seen++;
            end
        end
        if (!rst_n || note_xfer || res_xfer)
            idle_cnt = 0;
        else
        begin
            idle_cnt++;
            if (idle_cnt == IDLE_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        ending_t     ending;
        logic [31:0] nsz;
        logic [31:0] dsz;
        logic [31:0] ntype;
        logic [31:0] owner;
        logic [31:0] flip;
        bit          use_owner;
        bit          mid_done;
        int          note_bytes;
        int unsigned pick;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // length over the limit: bytes are dropped
        write_seg_len(17'h1FFFF);
        byte_q.push_back(8'h00);
        byte_q.push_back(8'hFF);
        byte_q.push_back(8'h55);
        byte_q.push_back(8'hAA);
        drain_idle();
        write_seg_len(SEG_W'(MAX_SEG));
        queue_note(4, 0, ID_TYPE, GNU_OWNER_LE, 1'b1);
        queue_note(0, 0, 32'hFFFF_FFFF, '0, 1'b0);

        note_bytes = 0;
        mid_done   = 1'b0;
        while (note_bytes < 560)
        begin
            use_owner = 1'b1;
            owner     = GNU_OWNER_LE;
            nsz       = 4;
            dsz       = $urandom_range(1, 8);
            ntype     = ID_TYPE;
            case ($urandom_range(0, 9))
                5:
                begin
                    flip  = $urandom_range(1, 255);
                    owner = GNU_OWNER_LE ^ (flip << (8 * $urandom_range(0, 3)));
                    dsz   = $urandom_range(1, 16);
                end
                6:  dsz = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(65, 72);
                7:  nsz = ($urandom_range(0, 1) == 0) ? 3 : 5;
                8:
                begin
                    flip  = 32'h1 << $urandom_range(0, 31);
                    ntype = ID_TYPE ^ flip;
                end
                9:
                begin
                    nsz       = 0;
                    dsz       = 0;
                    use_owner = 1'b0;
                    ntype     = $urandom;
                end
                default:
                begin
                    nsz       = $urandom_range(0, 9);
                    dsz       = $urandom_range(0, 24);
                    ntype     = $urandom;
                    use_owner = 1'b0;
                end
            endcase
            queue_note(nsz, dsz, ntype, owner, use_owner);
            note_bytes += HDR_BYTES + int'(pad4(nsz)) + int'(pad4(dsz));
            if (!mid_done && note_bytes >= 280)
            begin
                // parser must hold its place across an over-limit interval
                mid_done = 1'b1;
                drain_idle();
                write_seg_len(SEG_W'(MAX_SEG + 1));
                queue_random(6);
                drain_idle();
                write_seg_len(SEG_W'($urandom_range(4000, MAX_SEG)));
            end
        end
        drain_idle();

        pick = $urandom_range(0, 7);
        ending = (pick < 4) ? END_BUILD_ID : ending_t'(pick - 3);
        case (ending)
            END_BUILD_ID:
            begin
                pick = $urandom_range(0, 3);
                dsz  = (pick == 0) ? MAX_ID : (pick == 1) ? 1 : $urandom_range(2, 63);
                queue_note(4, dsz, ID_TYPE, GNU_OWNER_LE, 1'b1);
            end
            END_SHORT_TAIL:
                write_seg_len(SEG_W'(seen_cnt + $urandom_range(0, HDR_BYTES - 1)));
            END_AFTER_NOTE:
            begin
                nsz = $urandom_range(0, 6);
                dsz = $urandom_range(0, 10);
                write_seg_len(SEG_W'(seen_cnt + HDR_BYTES + pad4(nsz) + pad4(dsz) +
                                     $urandom_range(0, HDR_BYTES - 1)));
                queue_note(nsz, dsz, $urandom, '0, 1'b0);
            end
            END_HEADER_OVERRUN:
            begin
                write_seg_len(SEG_W'(seen_cnt + HDR_BYTES + $urandom_range(0, 40)));
                pick = $urandom_range(0, 2);
                nsz  = (pick == 0) ? 32'hFFFF_FFFF : 32'd4;
                dsz  = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF : MAX_ID;
                queue_word(nsz);
                queue_word(dsz);
                queue_word(ID_TYPE);
            end
            default:
                write_seg_len('0);
        endcase
        queue_random(6);
        drain_idle();
        write_seg_len(SEG_W'($urandom_range(0, 17'h1FFFF)));
        queue_random(4);
        drain_idle();

        if (expect_q.size() != 0)
        begin
            $error("%0d expected results never arrived", expect_q.size());
            err_cnt++;
        end
        $display("Run: %0d bytes transferred, %0d results checked, %0d register writes.",
                 bytes_in, results_seen, cfg_writes);
        $display("Search ended by %s.", ending.name());
        if (err_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/ebid_pkg.sv
rtl/core/ebid_parser.sv
rtl/core/ebid_out_fifo.sv
rtl/core/elf_build_id_note_parser.sv
verif/tb_elf_build_id_note_parser.sv
